/* rtl/ttf_pkg.sv */
// Shared types and constants for the triangle tangent frame block.
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

  // One triangle corner as it arrives on the input channel.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } corner_t;

  // One tangent frame as it leaves on the output channel.
  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate_uv;
  } frame_t;

  // |det| threshold, 1e-6 in Q.60.
  localparam logic [63:0]        DetEps = 64'd1152921504607;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // Iteration counts of the serial root / divide unit.
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;

  // Control between top level and sequencer.
  typedef struct packed {
    logic start;
    logic take;
  } ttf_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttf_sts_t;

  // Control between sequencer and root / divide unit.
  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_cmd_t;

endpackage

`default_nettype wire

/* rtl/ttf_divsqrt.sv */
// Serial square root and divide unit, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ttf_divsqrt import ttf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ds_cmd_t     cmd,
  input  logic [63:0] operand,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  logic        running;
  ds_mode_t    mode;
  logic [5:0]  steps;
  logic [34:0] rem;
  logic [63:0] shreg;
  logic [31:0] root;
  logic [31:0] dvs;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [35:0] diff;
  logic        fits;

  // Bring down the next digit and try the subtract.
  always_comb begin
    if (mode == DS_SQRT) begin
      rem_sh = {rem[32:0], shreg[63:62]};
      trial  = {1'b0, root, 2'b01};
    end else begin
      rem_sh = {rem[33:0], shreg[63]};
      trial  = {3'b000, dvs};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    fits = ~diff[35];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running <= 1'b1;
        mode    <= cmd.mode;
        root    <= '0;
        dvs     <= divisor;
        if (cmd.mode == DS_SQRT) begin
          steps <= 6'(SqrtSteps);
          rem   <= '0;
          shreg <= operand;
        end else begin
          // Quotient fits in DivSteps bits, so the top bits start as remainder.
          steps <= 6'(DivSteps);
          rem   <= {4'b0000, operand[61:31]};
          shreg <= {operand[30:0], 33'd0};
        end
      end else if (running) begin
        rem   <= fits ? diff[34:0] : rem_sh;
        root  <= {root[30:0], fits};
        shreg <= (mode == DS_SQRT) ? {shreg[61:0], 2'b00} : {shreg[62:0], 1'b0};
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign result = root;

endmodule

`default_nettype wire

/* rtl/ttf_core.sv */
// Sequencer and shared multiply-accumulate datapath for one triangle.
`timescale 1ns / 1ps
`default_nettype none

module ttf_core import ttf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ttf_cmd_t cmd,
  output ttf_sts_t sts,
  input  corner_t  c0,
  input  corner_t  c1,
  input  corner_t  c2,
  output frame_t   result
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_MUL     = 10'b0000000010,
    ST_ACC     = 10'b0000000100,
    ST_STORE   = 10'b0000001000,
    ST_SHIFT   = 10'b0000010000,
    ST_SQRT    = 10'b0000100000,
    ST_DIVGO   = 10'b0001000000,
    ST_DIVWAIT = 10'b0010000000,
    ST_NEXT    = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_t;

  typedef enum logic [3:0] {
    J_E1  = 4'd0,
    J_E2  = 4'd1,
    J_D1  = 4'd2,
    J_D2  = 4'd3,
    J_DET = 4'd4,
    J_T   = 4'd5,
    J_H   = 4'd6,
    J_BT  = 4'd7,
    J_DOT = 4'd8,
    J_SQ  = 4'd9
  } job_t;

  function automatic logic signed [31:0] pos_of(input corner_t c, input logic [1:0] i);
    case (i)
      2'd0:    pos_of = c.pos_x;
      2'd1:    pos_of = c.pos_y;
      default: pos_of = c.pos_z;
    endcase
  endfunction

  // Third coordinate of a UV pair reads as zero.
  function automatic logic signed [31:0] tex_of(input corner_t c, input logic [1:0] i);
    case (i)
      2'd0:    tex_of = c.tex_u;
      2'd1:    tex_of = c.tex_v;
      default: tex_of = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] nrm_of(input corner_t c, input logic [1:0] i);
    logic [15:0] v;
    case (i)
      2'd0:    v = c.normal_x;
      2'd1:    v = c.normal_y;
      default: v = c.normal_z;
    endcase
    nrm_of = {{16{v[15]}}, v};
  endfunction

  // Q.28 to Q1.14, half away from zero, saturated to one.
  function automatic logic signed [15:0] round_q14(input logic [63:0] m, input logic neg);
    logic [63:0] s;
    logic [15:0] q;
    s = m + 64'd8192;
    if (s[63:14] > 50'd16384) q = 16'd16384;
    else q = s[29:14];
    round_q14 = neg ? -$signed(q) : $signed(q);
  endfunction

  state_t state;
  job_t   job;
  job_t   vjob;
  logic [1:0] comp;
  logic [1:0] term;

  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic [63:0]        mag [3];
  logic               sgn [3];
  logic [31:0]        len;

  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] d1 [2];
  logic signed [31:0] d2 [2];
  logic signed [31:0] hb [3];
  logic signed [15:0] tan [3];
  logic signed [15:0] bt [3];
  logic               degen;
  logic               det_neg;

  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic               op_neg;
  logic [1:0]         last_term;
  logic [1:0]         nx;
  logic [1:0]         pv;
  logic [1:0]         na;
  logic [1:0]         ta;
  logic signed [63:0] mul_w;
  logic signed [65:0] prod_x;
  logic signed [65:0] acc_abs;
  logic [63:0]        acc_mag;
  logic [63:0]        mag_or;
  logic [63:0]        shifted;
  logic [63:0]        dividend;
  logic [31:0]        qs;
  logic               is_solve;

  ds_cmd_t     ds_cmd;
  logic [63:0] ds_operand;
  logic        ds_done;
  logic [31:0] ds_result;

  // Operand select for the current term.
  always_comb begin
    nx = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
    pv = (comp == 2'd0) ? 2'd2 : comp - 2'd1;
    na = term[0] ? pv : nx;
    ta = term[0] ? nx : pv;
    op_a   = '0;
    op_b   = '0;
    op_neg = term[0];
    case (job)
      J_E1: begin
        op_a = term[0] ? pos_of(c0, comp) : pos_of(c1, comp);
        op_b = 32'sd1;
      end
      J_E2: begin
        op_a = term[0] ? pos_of(c0, comp) : pos_of(c2, comp);
        op_b = 32'sd1;
      end
      J_D1: begin
        op_a = term[0] ? tex_of(c0, comp) : tex_of(c1, comp);
        op_b = 32'sd1;
      end
      J_D2: begin
        op_a = term[0] ? tex_of(c0, comp) : tex_of(c2, comp);
        op_b = 32'sd1;
      end
      J_DET: begin
        op_a = term[0] ? d1[1] : d1[0];
        op_b = term[0] ? d2[0] : d2[1];
      end
      J_T: begin
        op_a = term[0] ? e2[comp] : e1[comp];
        op_b = term[0] ? d1[1] : d2[1];
      end
      J_H: begin
        op_a = term[0] ? e1[comp] : e2[comp];
        op_b = term[0] ? d2[0] : d1[0];
      end
      J_BT: begin
        op_a = nrm_of(c2, na);
        op_b = {{16{tan[ta][15]}}, tan[ta]};
      end
      J_DOT: begin
        op_a   = {{16{bt[term][15]}}, bt[term]};
        op_b   = hb[term];
        op_neg = 1'b0;
      end
      J_SQ: begin
        op_a   = {1'b0, mag[term][30:0]};
        op_b   = {1'b0, mag[term][30:0]};
        op_neg = 1'b0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign last_term = (job == J_DOT || job == J_SQ) ? 2'd2 : 2'd1;
  assign mul_w     = op_a * op_b;
  assign prod_x    = {{2{prod[63]}}, prod};
  assign acc_abs   = acc[65] ? -acc : acc;
  assign acc_mag   = acc_abs[63:0];
  assign mag_or    = mag[0] | mag[1] | mag[2];
  assign is_solve  = (job == J_T) || (job == J_H);

  // Divide operand: (mag << frac) + len/2, frac 14 for the tangent.
  always_comb begin
    if (vjob == J_T) shifted = {19'd0, mag[comp][30:0], 14'd0};
    else shifted = {3'd0, mag[comp][30:0], 30'd0};
    dividend = shifted + {33'd0, len[31:1]};
    qs = sgn[comp] ? -ds_result : ds_result;
  end

  assign ds_cmd.start = (state == ST_STORE && job == J_SQ) || (state == ST_DIVGO);
  assign ds_cmd.mode  = (state == ST_DIVGO) ? DS_DIV : DS_SQRT;
  assign ds_operand   = (state == ST_DIVGO) ? dividend : acc[63:0];

  ttf_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ds_cmd),
    .operand (ds_operand),
    .divisor (len),
    .done    (ds_done),
    .result  (ds_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= J_E1;
      vjob  <= J_E1;
      comp  <= '0;
      term  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            job   <= J_E1;
            vjob  <= J_E1;
            comp  <= '0;
            term  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_w;
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= ((term == 2'd0) ? '0 : acc) + (op_neg ? -prod_x : prod_x);
          if (term == last_term) begin
            state <= ST_STORE;
          end else begin
            term  <= term + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_STORE: begin
          term <= '0;
          case (job)
            J_E1, J_E2, J_D1, J_D2, J_T, J_H: begin
              mag[comp] <= acc_mag;
              sgn[comp] <= acc[65] ^ (det_neg & is_solve);
              if (comp == 2'd2) begin
                state <= ST_SHIFT;
              end else begin
                comp  <= comp + 2'd1;
                state <= ST_MUL;
              end
            end
            J_SQ: begin
              state <= ST_SQRT;
            end
            J_DET: begin
              degen   <= acc_mag < DetEps;
              det_neg <= acc[65];
              comp    <= '0;
              state   <= ST_MUL;
              if (acc_mag < DetEps) begin
                tan[0] <= OneQ14;
                tan[1] <= '0;
                tan[2] <= '0;
                hb[0]  <= '0;
                hb[1]  <= '0;
                hb[2]  <= OneQ30;
                job    <= J_BT;
              end else begin
                job  <= J_T;
                vjob <= J_T;
              end
            end
            J_BT: begin
              bt[comp] <= round_q14(acc_mag, acc[65]);
              state    <= ST_MUL;
              if (comp == 2'd2) begin
                job  <= J_DOT;
                comp <= '0;
              end else begin
                comp <= comp + 2'd1;
              end
            end
            J_DOT: begin
              if (acc[65]) begin
                for (int i = 0; i < 3; i++) bt[i] <= -bt[i];
              end
              state <= ST_DONE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_SHIFT: begin
          if (mag_or == '0) begin
            // Zero vector: drop straight to a zero result.
            for (int i = 0; i < 3; i++) begin
              case (vjob)
                J_E1:    e1[i]  <= '0;
                J_E2:    e2[i]  <= '0;
                J_T:     tan[i] <= '0;
                J_H:     hb[i]  <= '0;
                default: ;
              endcase
            end
            if (vjob == J_D1) begin
              d1[0] <= '0;
              d1[1] <= '0;
            end
            if (vjob == J_D2) begin
              d2[0] <= '0;
              d2[1] <= '0;
            end
            state <= ST_NEXT;
          end else if (mag_or[63:31] != '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= {1'b0, mag[i][63:1]};
          end else if (!mag_or[30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= {mag[i][62:0], 1'b0};
          end else begin
            job   <= J_SQ;
            term  <= '0;
            state <= ST_MUL;
          end
        end
        ST_SQRT: begin
          if (ds_done) begin
            len   <= ds_result;
            comp  <= '0;
            state <= ST_DIVGO;
          end
        end
        ST_DIVGO: begin
          state <= ST_DIVWAIT;
        end
        ST_DIVWAIT: begin
          if (ds_done) begin
            case (vjob)
              J_E1:    e1[comp]  <= qs;
              J_E2:    e2[comp]  <= qs;
              J_D1:    if (comp != 2'd2) d1[comp[0]] <= qs;
              J_D2:    if (comp != 2'd2) d2[comp[0]] <= qs;
              J_T:     tan[comp] <= qs[15:0];
              J_H:     hb[comp]  <= qs;
              default: ;
            endcase
            if (comp == 2'd2) begin
              state <= ST_NEXT;
            end else begin
              comp  <= comp + 2'd1;
              state <= ST_DIVGO;
            end
          end
        end
        ST_NEXT: begin
          comp  <= '0;
          term  <= '0;
          state <= ST_MUL;
          case (vjob)
            J_E1: begin
              job  <= J_E2;
              vjob <= J_E2;
            end
            J_E2: begin
              job  <= J_D1;
              vjob <= J_D1;
            end
            J_D1: begin
              job  <= J_D2;
              vjob <= J_D2;
            end
            J_D2:    job <= J_DET;
            J_T: begin
              job  <= J_H;
              vjob <= J_H;
            end
            J_H:     job <= J_BT;
            default: state <= ST_IDLE;
          endcase
        end
        ST_DONE: begin
          if (cmd.take) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign sts.busy = (state != ST_IDLE);
  assign sts.done = (state == ST_DONE);

  always_comb begin
    result.tangent_x     = tan[0];
    result.tangent_y     = tan[1];
    result.tangent_z     = tan[2];
    result.bitangent_x   = bt[0];
    result.bitangent_y   = bt[1];
    result.bitangent_z   = bt[2];
    result.degenerate_uv = degen;
  end

endmodule

`default_nettype wire

/* rtl/triangle_tangent_frame.sv */
// Top level: corner intake, held corners, sequencer and output word register.
//
//   channel | direction | payload  | handshake
//   --------+-----------+----------+------------------------------
//   corner  | in        | corner_t | corner_valid / corner_stall
//   frame   | out       | frame_t  | frame_valid  / frame_stall
//
// Corners one and two of a triangle are held. The third runs the sequencer: six
// normalizations (shift, three squares, 32-step root, three 31-step divides) plus
// determinant, cross and dot products on the one multiplier.
// Hold corner_stall while that runs or a frame waits; rst clears count and output.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_frame import ttf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    corner_valid,
  output logic    corner_stall,
  input  corner_t corner,
  output logic    frame_valid,
  input  logic    frame_stall,
  output frame_t  frame
);

  logic [1:0] corner_count;
  logic       start_pend;
  corner_t    held0;
  corner_t    held1;
  corner_t    last_corner;
  logic       accept;
  logic       out_free;

  ttf_cmd_t   cmd;
  ttf_sts_t   sts;
  frame_t     core_frame;

  // Hold intake while the sequencer is busy or about to start.
  assign corner_stall = sts.busy | start_pend;
  assign accept       = corner_valid & ~corner_stall;
  assign out_free     = ~frame_valid | ~frame_stall;

  assign cmd.start = start_pend;
  assign cmd.take  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      start_pend   <= 1'b0;
    end else begin
      start_pend <= accept && (corner_count >= 2'd2);
      if (accept) begin
        // Any count of two or more closes the triangle.
        corner_count <= (corner_count >= 2'd2) ? 2'd0 : corner_count + 2'd1;
      end
    end
  end

  // Held corners: payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (corner_count)
        2'd0:    held0 <= corner;
        2'd1:    held1 <= corner;
        default: last_corner <= corner;
      endcase
    end
  end

  ttf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .c0     (held0),
    .c1     (held1),
    .c2     (last_corner),
    .result (core_frame)
  );

  // Output word register: load when free, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (sts.done && out_free) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done && out_free) frame <= core_frame;
  end

endmodule

`default_nettype wire

/* rtl/ttf_checker.sv */
// Port-level assertions for the triangle tangent frame block, with bind.
`timescale 1ns / 1ps
`default_nettype none

module ttf_checker import ttf_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   corner_stall,
  input logic   frame_valid,
  input logic   frame_stall,
  input frame_t frame
);

  a_reset_out: assert property (@(posedge clk) rst |=> !frame_valid)
    else $error("frame word valid right after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> !corner_stall)
    else $error("corner intake stalled right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      frame_valid && frame_stall |=> frame_valid && $stable(frame))
    else $error("stalled frame word changed or dropped");

  a_degen: assert property (@(posedge clk) disable iff (rst)
      frame_valid && frame.degenerate_uv |->
        frame.tangent_x == OneQ14 && frame.tangent_y == 16'sd0 &&
        frame.tangent_z == 16'sd0)
    else $error("degenerate frame without fallback tangent");

  a_range: assert property (@(posedge clk) disable iff (rst)
      frame_valid |->
        frame.tangent_x <= OneQ14 && frame.tangent_x >= -OneQ14 &&
        frame.tangent_y <= OneQ14 && frame.tangent_y >= -OneQ14 &&
        frame.tangent_z <= OneQ14 && frame.tangent_z >= -OneQ14 &&
        frame.bitangent_x <= OneQ14 && frame.bitangent_x >= -OneQ14 &&
        frame.bitangent_y <= OneQ14 && frame.bitangent_y >= -OneQ14 &&
        frame.bitangent_z <= OneQ14 && frame.bitangent_z >= -OneQ14)
    else $error("frame component beyond unit range");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk          (clk),
  .rst          (rst),
  .corner_stall (corner_stall),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .frame        (frame)
);

`default_nettype wire
